// ----- hdl/xtea_pkg.sv -----
// Package for the XTEA block cipher unit: opcode type, pipeline record,
// key type and the round mixing function. No dependencies.
`default_nettype none

package xtea_pkg;

  localparam int unsigned XTEA_ROUNDS_DFLT = 32;
  localparam logic [31:0] XTEA_DELTA       = 32'h9E37_79B9;
  localparam int unsigned XTEA_BLK_W       = 64;
  localparam int unsigned XTEA_WORD_W      = 32;

  typedef enum logic [0:0] {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } xtea_op_t;

  // Four key words, index 0 holds key bytes 0..3.
  typedef logic [3:0][XTEA_WORD_W-1:0] xtea_key_t;

  // One slot of the round pipeline.
  typedef struct packed {
    logic                   valid;
    xtea_op_t               op;
    logic [XTEA_WORD_W-1:0] y;
    logic [XTEA_WORD_W-1:0] z;
  } xtea_stage_t;

  // Status of the output buffer, seen by the pipeline control.
  typedef struct packed {
    logic full;
    logic empty;
  } xtea_buf_status_t;

  // XTEA mix: (((w << 4) ^ (w >> 5)) + w) ^ (sum + k), all modulo 2^32.
  function automatic logic [XTEA_WORD_W-1:0] xtea_mix(
    input logic [XTEA_WORD_W-1:0] w,
    input logic [XTEA_WORD_W-1:0] sum,
    input logic [XTEA_WORD_W-1:0] k
  );
    logic [XTEA_WORD_W-1:0] t;
    t = ((w << 4) ^ (w >> 5)) + w;
    return t ^ (sum + k);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/xtea_round_cell.sv -----
// One half-round cell of the XTEA pipeline: updates one word of the block.
// Depends on xtea_pkg.
`default_nettype none

module xtea_round_cell #(
  parameter int unsigned ROUNDS = xtea_pkg::XTEA_ROUNDS_DFLT,
  parameter int unsigned STAGE  = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  xtea_pkg::xtea_key_t key,
  input  xtea_pkg::xtea_stage_t d_in,
  output xtea_pkg::xtea_stage_t q_out
);
  import xtea_pkg::*;

  // Even cells do the first half of a round, odd cells the second half.
  localparam int unsigned HALF    = STAGE / 2;
  localparam bit          ODD     = (STAGE % 2) == 1;
  localparam int unsigned ENC_MUL = HALF + (ODD ? 1 : 0);
  localparam int unsigned DEC_MUL = ROUNDS - HALF - (ODD ? 1 : 0);

  localparam logic [63:0] ENC_PROD = 64'(XTEA_DELTA) * 64'(ENC_MUL);
  localparam logic [63:0] DEC_PROD = 64'(XTEA_DELTA) * 64'(DEC_MUL);
  localparam logic [31:0] ENC_SUM  = ENC_PROD[31:0];
  localparam logic [31:0] DEC_SUM  = DEC_PROD[31:0];
  localparam logic [1:0]  ENC_KSEL = ODD ? ENC_SUM[12:11] : ENC_SUM[1:0];
  localparam logic [1:0]  DEC_KSEL = ODD ? DEC_SUM[1:0]   : DEC_SUM[12:11];

  xtea_stage_t            q_r;
  xtea_stage_t            q_nxt;
  logic                   upd_y;
  logic [XTEA_WORD_W-1:0] src;
  logic [XTEA_WORD_W-1:0] dst;
  logic [XTEA_WORD_W-1:0] sum;
  logic [XTEA_WORD_W-1:0] kw;
  logic [XTEA_WORD_W-1:0] m;
  logic [XTEA_WORD_W-1:0] res;

  always_comb begin
    if (d_in.op == OP_ENCRYPT) begin
      upd_y = !ODD;
      sum   = ENC_SUM;
      kw    = key[ENC_KSEL];
    end else begin
      upd_y = ODD;
      sum   = DEC_SUM;
      kw    = key[DEC_KSEL];
    end
    src = upd_y ? d_in.z : d_in.y;
    dst = upd_y ? d_in.y : d_in.z;
    m   = xtea_mix(src, sum, kw);
    res = (d_in.op == OP_ENCRYPT) ? (dst + m) : (dst - m);

    q_nxt = d_in;
    if (upd_y) begin
      q_nxt.y = res;
    end else begin
      q_nxt.z = res;
    end
  end

  // Only the valid bit is reset; the data fields simply follow the enable.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r.valid <= q_nxt.valid;
    end
    if (en) begin
      q_r.op <= q_nxt.op;
      q_r.y  <= q_nxt.y;
      q_r.z  <= q_nxt.z;
    end
  end

  assign q_out = q_r;

endmodule

`default_nettype wire

// ----- hdl/xtea_out_buf.sv -----
// Two-entry output buffer between the round pipeline and the result stream.
// Depends on xtea_pkg.
`default_nettype none

module xtea_out_buf (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [xtea_pkg::XTEA_BLK_W-1:0] wr_data,
  input  logic                         rd_ready,
  output logic                         rd_valid,
  output logic [xtea_pkg::XTEA_BLK_W-1:0] rd_data,
  output xtea_pkg::xtea_buf_status_t   status
);
  import xtea_pkg::*;

  logic [XTEA_BLK_W-1:0] mem [2];
  logic                  wr_ptr_r;
  logic                  wr_ptr_nxt;
  logic                  rd_ptr_r;
  logic                  rd_ptr_nxt;
  logic [1:0]            cnt_r;
  logic [1:0]            cnt_nxt;
  logic                  pop;

  assign pop = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_en ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(wr_en) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_valid     = cnt_r != 2'd0;
  assign rd_data      = mem[rd_ptr_r];
  assign status.full  = cnt_r == 2'd2;
  assign status.empty = cnt_r == 2'd0;

endmodule

`default_nettype wire

// ----- hdl/xtea_block_cipher_unit.sv -----
// Top level of the XTEA block cipher unit: key registers, a chain of
// half-round cells and the output buffer. Depends on xtea_pkg,
// xtea_round_cell and xtea_out_buf.
//
//   Channel   Direction  Signals                          Content
//   in_       sink       in_tvalid/in_tready/in_tdata/    block_in, opcode in tuser
//                        in_tuser
//   out_      source     out_tvalid/out_tready/out_tdata  block_out
//   cfg_      APB slave  psel/penable/pwrite/paddr/...    key_word_0..3 at 0x0..0xC
//
// The cipher is a chain of 2*ROUNDS cells, one half-round each. A block
// passes the register of every cell and then the output buffer on its way
// to the result stream. Unless the chain holds, one block is accepted in
// every cycle. The chain advances as a whole; it holds only when the
// two-entry output buffer is full and the last cell holds a finished block.
// Reset is synchronous, active low, and clears the key registers, the cell
// valid bits and the buffer.
`default_nettype none

module xtea_block_cipher_unit #(
  parameter int unsigned ROUNDS = xtea_pkg::XTEA_ROUNDS_DFLT
) (
  input  logic        clk,
  input  logic        rst_n,

  // Input block stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] block_in
  input  logic [0:0]  in_tuser,   // [0] opcode (0 encrypt, 1 decrypt)

  // Result block stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] block_out

  // Key configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import xtea_pkg::*;

  localparam int unsigned NCELLS = 2 * ROUNDS;

  // Key registers. The register index sits in address bits [3:2].
  xtea_key_t key_r;
  logic      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = key_r[cfg_paddr[3:2]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_wr) begin
      key_r[cfg_paddr[3:2]] <= cfg_pwdata;
    end
  end

  // Cell chain. stage[0] is the incoming transaction, stage[i+1] the
  // register of cell i.
  xtea_stage_t      stage [NCELLS+1];
  xtea_buf_status_t buf_st;
  logic             pipe_en;
  xtea_stage_t      last;

  assign last = stage[NCELLS];

  // The chain only stalls when the finished block in the last cell has no
  // room in the output buffer. This depends on registers alone.
  assign pipe_en   = !(buf_st.full && last.valid);
  assign in_tready = pipe_en;

  assign stage[0] = '{valid: in_tvalid && in_tready,
                      op:    xtea_op_t'(in_tuser[0]),
                      y:     in_tdata[63:32],
                      z:     in_tdata[31:0]};

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    xtea_round_cell #(
      .ROUNDS (ROUNDS),
      .STAGE  (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (pipe_en),
      .key   (key_r),
      .d_in  (stage[i]),
      .q_out (stage[i+1])
    );
  end

  // A finished block moves into the buffer whenever the chain advances.
  xtea_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (pipe_en && last.valid),
    .wr_data  ({last.y, last.z}),
    .rd_ready (out_tready),
    .rd_valid (out_tvalid),
    .rd_data  (out_tdata),
    .status   (buf_st)
  );

  // The buffer cannot be full and empty at once.
  a_buf_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(buf_st.full && buf_st.empty))
    else $error("output buffer reports full and empty");

  // A finished block waiting on a full buffer must block new transactions.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (buf_st.full && last.valid) |-> !in_tready)
    else $error("input accepted while chain is stalled");

  // While the chain is stalled the last cell keeps its block.
  a_stall_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(last))
    else $error("last cell changed during a stall");

  // An accepted transaction occupies the first cell on the next cycle.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> stage[1].valid)
    else $error("accepted block missing from the first cell");

endmodule

`default_nettype wire

// ----- tb/sv/xtea_block_cipher_unit_tb.sv -----
// Self-checking testbench for the XTEA block cipher unit.
// It depends on xtea_pkg for the opcode type and on the RTL top level.
// It needs no other file.
`timescale 1ns / 100ps

module xtea_block_cipher_unit_tb;
  import xtea_pkg::*;

  // The block is built with its default round count. The testbench keeps
  // its own copy of that value and of the key schedule constant.
  localparam int unsigned N_ROUNDS  = 32;
  localparam logic [31:0] DELTA     = 32'h9E37_79B9;
  // A block passes the chain of half-round cells and then the output
  // buffer before it reaches the result stream.
  localparam int unsigned LATENCY   = 2 * N_ROUNDS + 1;
  // This is the length of the long receiver hold-off that fills the chain.
  localparam int unsigned HOLD_CYCLES = 300;
  // The longest quiet stretch of a correct run is the hold-off plus a full
  // pass through the chain and some random stalls. The limit is several
  // times that.
  localparam int unsigned QUIET_LIMIT = 2000;

  // The key words sit at word-aligned byte addresses.
  typedef enum logic [3:0] {
    REG_KEY_WORD_0 = 4'h0,
    REG_KEY_WORD_1 = 4'h4,
    REG_KEY_WORD_2 = 4'h8,
    REG_KEY_WORD_3 = 4'hC
  } key_reg_t;

  // One row of the directed stimulus table.
  typedef struct packed {
    xtea_op_t    op;
    logic [63:0] blk;
  } dir_row_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata    = '0;   // [63:0] block_in
  logic [0:0]  in_tuser    = OP_ENCRYPT; // [0] opcode
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [63:0] out_tdata;          // [63:0] block_out
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // The key as the testbench believes the block holds it.
  logic [31:0] key_model [4] = '{32'h0, 32'h0, 32'h0, 32'h0};
  // These are the result blocks that the block still owes, oldest first.
  logic [63:0] blocks_due [$];

  // Idling controls. The receiver percentage and the hold flag are read by
  // the ready process at the clock edge, so they change by nonblocking
  // assignment only.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        recv_hold     = 1'b0;

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned enc_count    = 0;
  int unsigned dec_count    = 0;
  int unsigned key_settings = 0;
  int unsigned quiet_cycles = 0;

  // The last transaction sent and its predicted result let the stimulus
  // feed a result back in the opposite direction.
  xtea_op_t    last_op  = OP_ENCRYPT;
  logic [63:0] last_out = '0;

  dir_row_t directed_rows [18];

  xtea_block_cipher_unit #(.ROUNDS(N_ROUNDS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // This is the XTEA round function on one word: shifted copies of the
  // word, folded back onto it, then mixed with the running sum plus a key
  // word.
  function automatic logic [31:0] feistel_mix(input logic [31:0] w,
                                              input logic [31:0] s,
                                              input logic [31:0] k);
    return (((w << 4) ^ (w >> 5)) + w) ^ (s + k);
  endfunction

  // This predicts one result block. Encryption runs the sum up from zero;
  // decryption starts it at DELTA times the round count and undoes the
  // rounds in reverse order.
  function automatic logic [63:0] xtea_transform(input xtea_op_t op,
                                                 input logic [63:0] blk);
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] s;
    y = blk[63:32];
    z = blk[31:0];
    if (op == OP_ENCRYPT) begin
      s = '0;
      repeat (N_ROUNDS) begin
        y = y + feistel_mix(z, s, key_model[s[1:0]]);
        s = s + DELTA;
        z = z + feistel_mix(y, s, key_model[s[12:11]]);
      end
    end else begin
      s = DELTA * 32'(N_ROUNDS);
      repeat (N_ROUNDS) begin
        z = z - feistel_mix(y, s, key_model[s[12:11]]);
        s = s - DELTA;
        y = y - feistel_mix(z, s, key_model[s[1:0]]);
      end
    end
    return {y, z};
  endfunction

  function automatic void note_mismatch(input string what,
                                        input logic [63:0] want,
                                        input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
  endfunction

  // Random words lean toward the corner values now and then.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  // The receiver drops tready at the rate that the current idling mode
  // asks, and holds it low throughout a hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every accepted result is compared with the oldest block still due.
  always @(posedge clk) begin : check_results
    logic [63:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (blocks_due.size() == 0) begin
        note_mismatch("result with nothing due", '0, out_tdata);
      end else begin
        want = blocks_due.pop_front();
        results_seen++;
        if (out_tdata !== want)
          note_mismatch("block_out", want, out_tdata);
      end
    end
  end

  // The watchdog ends the run when no transaction moves on any port for
  // too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("[%0t] no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("** xtea_block_cipher_unit: FAILED **");
        $finish;
      end
    end
  end

  // One APB transfer: a setup phase, an access phase held until pready,
  // then a release of the port, so that transfers never need two
  // assignments to psel in the same step.
  task automatic apb_transfer(input bit wr, input key_reg_t key_reg,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= key_reg;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic key_read_check(input key_reg_t key_reg, input logic [31:0] want);
    logic [31:0] got;
    apb_transfer(1'b0, key_reg, '0, got);
    if (got !== want)
      note_mismatch($sformatf("read of key register %s", key_reg.name()), 64'(want),
                    64'(got));
  endtask

  // The key model changes only after the write transaction, and only while
  // no block is in flight.
  task automatic key_write_verify(input key_reg_t key_reg, input logic [31:0] value);
    logic [31:0] unused;
    apb_transfer(1'b1, key_reg, value, unused);
    key_model[key_reg[3:2]] = value;
    key_read_check(key_reg, value);
  endtask

  task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                          input logic [31:0] k2, input logic [31:0] k3);
    key_write_verify(REG_KEY_WORD_0, k0);
    key_write_verify(REG_KEY_WORD_1, k1);
    key_write_verify(REG_KEY_WORD_2, k2);
    key_write_verify(REG_KEY_WORD_3, k3);
    key_settings++;
  endtask

  // This offers one block and waits for its transaction. The sender may
  // idle first. After the task returns, tvalid stays high, so the next call
  // either keeps it high with new data or lowers it, never both.
  task automatic send_block(input xtea_op_t op, input logic [63:0] blk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= blk;
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    last_op  = op;
    last_out = xtea_transform(op, blk);
    blocks_due.push_back(last_out);
    if (op == OP_ENCRYPT) enc_count++;
    else dec_count++;
  endtask

  // The sender stops and waits until every block due has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (blocks_due.size() != 0);
  endtask

  task automatic hold_receiver(input int unsigned cycles);
    recv_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    recv_hold <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // A random phase. About a quarter of the blocks feed the last result back
  // in the opposite direction, which must give back the block before it. The
  // rest are random blocks with random opcodes.
  task automatic run_phase(input int unsigned n_items, input bit with_hold,
                           input bit with_pause);
    xtea_op_t    op;
    logic [63:0] blk;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (with_hold && i == 10) begin
        fork
          hold_receiver(HOLD_CYCLES);
        join_none
      end
      if (with_pause && i == n_items / 2)
        drain();
      if ($urandom_range(3) == 0) begin
        op  = (last_op == OP_ENCRYPT) ? OP_DECRYPT : OP_ENCRYPT;
        blk = last_out;
      end else begin
        op  = xtea_op_t'($urandom_range(1));
        blk = {pick_word(), pick_word()};
      end
      send_block(op, blk);
    end
    drain();
  endtask

  initial begin
    // The directed table covers the all-zero and all-one blocks, single bits
    // at the edges of each word, alternating patterns and a counting
    // pattern, mostly in both directions. It runs with the key as reset
    // leaves it.
    directed_rows = '{
      '{OP_ENCRYPT, 64'h0000_0000_0000_0000},
      '{OP_DECRYPT, 64'h0000_0000_0000_0000},
      '{OP_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF},
      '{OP_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF},
      '{OP_ENCRYPT, 64'h8000_0000_0000_0000},
      '{OP_DECRYPT, 64'h8000_0000_0000_0000},
      '{OP_ENCRYPT, 64'h0000_0000_0000_0001},
      '{OP_DECRYPT, 64'h0000_0000_0000_0001},
      '{OP_ENCRYPT, 64'h0000_0001_0000_0000},
      '{OP_DECRYPT, 64'h0000_0000_8000_0000},
      '{OP_ENCRYPT, 64'hAAAA_AAAA_5555_5555},
      '{OP_DECRYPT, 64'hAAAA_AAAA_5555_5555},
      '{OP_ENCRYPT, 64'h5555_5555_AAAA_AAAA},
      '{OP_ENCRYPT, 64'h0123_4567_89AB_CDEF},
      '{OP_DECRYPT, 64'h0123_4567_89AB_CDEF},
      '{OP_ENCRYPT, 64'hFFFF_FFFF_0000_0000},
      '{OP_DECRYPT, 64'h0000_0000_FFFF_FFFF},
      '{OP_ENCRYPT, 64'h7FFF_FFFF_7FFF_FFFF}
    };

    // Reset is held once, at the start of the run.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // All key words read back as zero after reset.
    key_read_check(REG_KEY_WORD_0, 32'h0);
    key_read_check(REG_KEY_WORD_1, 32'h0);
    key_read_check(REG_KEY_WORD_2, 32'h0);
    key_read_check(REG_KEY_WORD_3, 32'h0);

    // In the first mode the sender idles a third of the time and the
    // receiver more than half.
    set_idling(33, 57);
    foreach (directed_rows[i])
      send_block(directed_rows[i].op, directed_rows[i].blk);
    drain();

    // The all-ones key is used with a long receiver hold-off. The chain and
    // the output buffer fill up and tready on the input must fall.
    load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(250, 1'b1, 1'b0);

    load_key(pick_word(), pick_word(), pick_word(), pick_word());
    run_phase(250, 1'b0, 1'b0);

    // The modes swap: the sender idles more than half the time and the
    // receiver a third.
    set_idling(57, 33);
    load_key($urandom(), $urandom(), $urandom(), $urandom());
    run_phase(300, 1'b0, 1'b1);

    // An explicit all-zero key, written rather than left from reset.
    load_key(32'h0, 32'h0, 32'h0, 32'h0);
    run_phase(200, 1'b0, 1'b0);

    // Neither side idles, so blocks stream back to back.
    set_idling(0, 0);
    load_key($urandom(), $urandom(), $urandom(), $urandom());
    run_phase(400, 1'b0, 1'b0);

    // Spurious results may still show up after everything due has come.
    repeat (LATENCY + 8) @(posedge clk);

    $display("Run covered %0d encryptions and %0d decryptions under %0d key settings,",
             enc_count, dec_count, key_settings + 1);
    $display("with %0d results checked across three idling modes and one long hold-off.",
             results_seen);
    if (mismatches == 0) begin
      $display("** xtea_block_cipher_unit: PASSED **");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("** xtea_block_cipher_unit: FAILED **");
    end
    $finish;
  end

endmodule
